### hdl/erld_pkg.sv
package erld_pkg;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SIZE_W   = 4;
	localparam int unsigned LIMIT_W  = 63;
	localparam int unsigned VALUE_W  = 64;

	// Legal range of a header size nibble
	localparam logic [SIZE_W-1:0] SIZE_MIN = 4'd1;
	localparam logic [SIZE_W-1:0] SIZE_MAX = 4'd8;

	// Bit of an offset byte that carries the sign
	localparam int unsigned SIGN_BIT = 7;

	// Result status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_BAD_SIZE = 1'b1;

	// One decoded run
	typedef struct packed {
		logic [VALUE_W-1:0]        run_length;
		logic signed [VALUE_W-1:0] run_offset;
		logic                      status;
		logic                      list_done;
	} run_result_t;

endpackage

### hdl/erld_core.sv
module erld_core import erld_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               list_start,
	input  logic [LIMIT_W-1:0] last_cluster_number,
	output logic               res_valid,
	output run_result_t        res
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_OFFSET = 2'd2
	} phase_t;

	phase_t              phase_q, phase_d, phase_eff;
	logic [SIZE_W-1:0]   length_size_q, length_size_d;
	logic [SIZE_W-1:0]   offset_size_q, offset_size_d;
	logic [SIZE_W-1:0]   byte_pos_q, byte_pos_d, pos_next;
	logic [VALUE_W-1:0]  length_acc_q, length_acc_d;
	logic [VALUE_W-1:0]  offset_acc_q, offset_acc_d;
	logic [VALUE_W-1:0]  cluster_sum_q, cluster_sum_d, sum_eff, sum_sat;
	logic                finished_q, finished_d, fin_eff;
	logic [SIZE_W-1:0]   ls, os;
	logic [VALUE_W-1:0]  byte_shift, off_merge, off_ext;
	logic [VALUE_W:0]    sum_wide;

	// Abandon any open list when a new one starts
	assign fin_eff   = finished_q & ~list_start;
	assign phase_eff = list_start ? PH_HEADER : phase_q;
	assign sum_eff   = list_start ? '0 : cluster_sum_q;

	// Place the byte at its little-endian position
	assign pos_next   = byte_pos_q + SIZE_W'(1);
	assign byte_shift = VALUE_W'(data_byte) << {byte_pos_q[2:0], 3'b000};
	assign off_merge  = offset_acc_q | byte_shift;

	// Sign-extend from bit 7 of the top offset byte
	always_comb begin
		off_ext = off_merge;
		if (data_byte[SIGN_BIT] && (offset_size_q < SIZE_MAX)) begin
			off_ext = off_merge | ({VALUE_W{1'b1}} << {offset_size_q[2:0], 3'b000});
		end
	end

	// Saturating running sum of run lengths
	assign sum_wide = {1'b0, sum_eff} + {1'b0, length_acc_q};
	assign sum_sat  = sum_wide[VALUE_W] ? {VALUE_W{1'b1}} : sum_wide[VALUE_W-1:0];

	assign ls = data_byte[SIZE_W-1:0];
	assign os = data_byte[BYTE_W-1:SIZE_W];

	// Next state and result for the byte in the input stage
	always_comb begin
		phase_d       = phase_eff;
		length_size_d = length_size_q;
		offset_size_d = offset_size_q;
		byte_pos_d    = byte_pos_q;
		length_acc_d  = length_acc_q;
		offset_acc_d  = offset_acc_q;
		cluster_sum_d = sum_eff;
		finished_d    = fin_eff;
		res_valid     = 1'b0;
		res           = '0;
		if (!fin_eff) begin
			case (phase_eff)
				PH_LENGTH: begin
					length_acc_d = length_acc_q | byte_shift;
					byte_pos_d   = pos_next;
					if (pos_next >= length_size_q) begin
						phase_d    = PH_OFFSET;
						byte_pos_d = '0;
					end
				end
				PH_OFFSET: begin
					offset_acc_d = off_merge;
					byte_pos_d   = pos_next;
					if (pos_next >= offset_size_q) begin
						offset_acc_d   = off_ext;
						cluster_sum_d  = sum_sat;
						phase_d        = PH_HEADER;
						byte_pos_d     = '0;
						res_valid      = 1'b1;
						res.run_length = length_acc_q;
						res.run_offset = off_ext;
						res.status     = STATUS_OK;
						if (sum_sat > {1'b0, last_cluster_number}) begin
							res.list_done = 1'b1;
							finished_d    = 1'b1;
						end
					end
				end
				default: begin
					// Header byte; the unused phase code lands here too
					if (!(ls inside {[SIZE_MIN:SIZE_MAX]}) || !(os inside {[SIZE_MIN:SIZE_MAX]})) begin
						res_valid     = 1'b1;
						res.status    = STATUS_BAD_SIZE;
						res.list_done = 1'b1;
						finished_d    = 1'b1;
						phase_d       = PH_HEADER;
					end else begin
						length_size_d = ls;
						offset_size_d = os;
						byte_pos_d    = '0;
						length_acc_d  = '0;
						offset_acc_d  = '0;
						phase_d       = PH_LENGTH;
					end
				end
			endcase
		end
	end

	// Hold decode state; advance only when the input stage moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			length_size_q <= '0;
			offset_size_q <= '0;
			byte_pos_q    <= '0;
			length_acc_q  <= '0;
			offset_acc_q  <= '0;
			cluster_sum_q <= '0;
			finished_q    <= 1'b1;
		end else if (step) begin
			phase_q       <= phase_d;
			length_size_q <= length_size_d;
			offset_size_q <= offset_size_d;
			byte_pos_q    <= byte_pos_d;
			length_acc_q  <= length_acc_d;
			offset_acc_q  <= offset_acc_d;
			cluster_sum_q <= cluster_sum_d;
			finished_q    <= finished_d;
		end
	end

endmodule

### hdl/extent_run_list_decoder.sv
// Extent run list decoder: one encoded byte per input transaction.
// A run result travels from its last offset byte through the input register, then the
// result register. Throughput: one byte per cycle while no result waits on a stalled
// output, set by the decode and sum-compare stage.
// Reset (arst_n low, asynchronous): pipeline empty, limit 0, decoder idle until list start.
module extent_run_list_decoder import erld_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration
	input  logic                 cfg_we,
	input  logic [LIMIT_W-1:0]   cfg_wdata,     // last_cluster_number
	// Byte stream in
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [BYTE_W-1:0]    s_axis_tdata,  // [7:0] data_byte
	input  logic                 s_axis_tuser,  // list_start
	// Run results out
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [2*VALUE_W-1:0] m_axis_tdata,  // [63:0] run_length, [127:64] run_offset
	output logic                 m_axis_tuser,  // status
	output logic                 m_axis_tlast   // list_done
);

	logic [LIMIT_W-1:0] limit_q;
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               start_s1;
	logic               res_valid;
	run_result_t        res;
	logic               out_valid_q;
	run_result_t        out_res_q;
	logic               out_free;
	logic               advance;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Stage handshake: a byte leaves the input stage unless its result is blocked
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!res_valid || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	erld_core u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (advance),
		.data_byte           (byte_s1),
		.list_start          (start_s1),
		.last_cluster_number (limit_q),
		.res_valid           (res_valid),
		.res                 (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_res_q.run_offset, out_res_q.run_length};
	assign m_axis_tuser  = out_res_q.status;
	assign m_axis_tlast  = out_res_q.list_done;

	// An error result always ends the list and carries no run
	a_error_ends_list: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == STATUS_BAD_SIZE))
		|-> (m_axis_tlast && (m_axis_tdata == '0)))
		else $error("error result without list end or with payload");

	// A produced result reaches the output register on the next cycle
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid) |=> m_axis_tvalid)
		else $error("decoded result lost");

	// A byte blocked in the input stage stays there unchanged
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(start_s1)))
		else $error("input stage overwritten while blocked");

	// A byte is only blocked when the result register is full and stalled
	a_block_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (out_valid_q && !m_axis_tready))
		else $error("input stage blocked without output stall");

endmodule

### dv/extent_run_list_decoder_tb.sv
`timescale 1ns / 1ps

module extent_run_list_decoder_tb;
	import erld_pkg::*;

	localparam int RESULT_LATENCY = 2;
	localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
	localparam int CYCLE_LIMIT    = 200_000;
	localparam int ITEMS_PER_SET  = 80;
	localparam int REPORT_MAX     = 10;

	typedef enum logic [1:0] {SEEK_HEADER, TAKE_LENGTH, TAKE_OFFSET} decode_phase_t;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TRICKLE} rx_mode_t;

	// One row of the directed byte table; pinned rows carry a literal expected run
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              start;
		logic              pinned;
		run_result_t       run;
	} byte_row_t;

	localparam run_result_t NO_RUN  = '0;
	localparam run_result_t BAD_RUN = '{run_length: '0, run_offset: '0,
		status: STATUS_BAD_SIZE, list_done: 1'b1};
	localparam run_result_t MIN_OFFSET_RUN = '{run_length: '0,
		run_offset: 64'sh8000_0000_0000_0000, status: STATUS_OK, list_done: 1'b0};
	localparam run_result_t MAX_LENGTH_RUN = '{run_length: '1,
		run_offset: 64'sd127, status: STATUS_OK, list_done: 1'b1};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [LIMIT_W-1:0]   cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata;   // [7:0] data_byte
	logic                 s_axis_tuser;   // list_start
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [2*VALUE_W-1:0] m_axis_tdata;   // [63:0] run_length, [127:64] run_offset
	logic                 m_axis_tuser;   // status
	logic                 m_axis_tlast;   // list_done

	// Literal expectation that travels with the byte it belongs to
	logic        pin_valid;
	run_result_t pin_run;

	// Predictor state
	decode_phase_t      dec_phase;
	logic [SIZE_W-1:0]  len_size, off_size, byte_pos;
	logic [VALUE_W-1:0] len_acc, off_acc, cluster_total;
	logic               list_ended;
	logic [LIMIT_W-1:0] lcn_limit;

	run_result_t pending_runs[$];
	run_result_t predicted_run, seen_run, wanted_run;
	logic        run_due, byte_used;
	int          decoded_items;
	int          failures;
	int          cycle_count;
	int          burst_left;
	logic        steady;
	rx_mode_t    rx_mode;
	logic [31:0] rx_tick;
	logic [LIMIT_W-1:0] limit_set[5];

	byte_row_t stim_table[0:29] = '{
		'{8'h11, 1'b0, 1'b0, NO_RUN},          // idle after reset: ignored
		'{8'h01, 1'b1, 1'b1, BAD_RUN},         // sparse run (offset size 0)
		'{8'h22, 1'b0, 1'b0, NO_RUN},          // after error: ignored
		'{8'h81, 1'b1, 1'b0, NO_RUN},          // length 1 byte, offset 8 bytes
		'{8'h00, 1'b0, 1'b0, NO_RUN},
		'{8'h00, 1'b0, 1'b0, NO_RUN},
		'{8'h00, 1'b0, 1'b0, NO_RUN},
		'{8'h00, 1'b0, 1'b0, NO_RUN},
		'{8'h00, 1'b0, 1'b0, NO_RUN},
		'{8'h00, 1'b0, 1'b0, NO_RUN},
		'{8'h00, 1'b0, 1'b0, NO_RUN},
		'{8'h00, 1'b0, 1'b0, NO_RUN},
		'{8'h80, 1'b0, 1'b1, MIN_OFFSET_RUN},  // zero length keeps the list open
		'{8'h18, 1'b0, 1'b0, NO_RUN},          // length 8 bytes, offset 1 byte
		'{8'hFF, 1'b0, 1'b0, NO_RUN},
		'{8'hFF, 1'b0, 1'b0, NO_RUN},
		'{8'hFF, 1'b0, 1'b0, NO_RUN},
		'{8'hFF, 1'b0, 1'b0, NO_RUN},
		'{8'hFF, 1'b0, 1'b0, NO_RUN},
		'{8'hFF, 1'b0, 1'b0, NO_RUN},
		'{8'hFF, 1'b0, 1'b0, NO_RUN},
		'{8'hFF, 1'b0, 1'b0, NO_RUN},
		'{8'h7F, 1'b0, 1'b1, MAX_LENGTH_RUN},  // largest length, sum hits the top
		'{8'hF9, 1'b1, 1'b1, BAD_RUN},         // size nibbles above range
		'{8'h11, 1'b1, 1'b0, NO_RUN},
		'{8'h22, 1'b1, 1'b0, NO_RUN},          // restart in the middle of a run
		'{8'h12, 1'b0, 1'b0, NO_RUN},
		'{8'h34, 1'b0, 1'b0, NO_RUN},
		'{8'hFE, 1'b0, 1'b0, NO_RUN},
		'{8'hFF, 1'b0, 1'b0, NO_RUN}
	};

	extent_run_list_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Decode one accepted byte; return 1 when it completes a run or an error
	function automatic logic decode_byte(input logic [BYTE_W-1:0] b, input logic st,
			output run_result_t res, output logic used);
		logic [SIZE_W-1:0]  ls, os;
		logic [VALUE_W:0]   wide_sum;
		res = NO_RUN;
		used = 1'b0;
		if (st) begin
			list_ended = 1'b0;
			cluster_total = '0;
			dec_phase = SEEK_HEADER;
		end
		if (list_ended)
			return 1'b0;
		used = 1'b1;
		case (dec_phase)
			TAKE_LENGTH: begin
				len_acc |= {56'd0, b} << (8 * (byte_pos & 4'd7));
				byte_pos = byte_pos + 4'd1;
				if (byte_pos >= len_size) begin
					dec_phase = TAKE_OFFSET;
					byte_pos = '0;
				end
				return 1'b0;
			end
			TAKE_OFFSET: begin
				off_acc |= {56'd0, b} << (8 * (byte_pos & 4'd7));
				byte_pos = byte_pos + 4'd1;
				if (byte_pos < off_size)
					return 1'b0;
				// sign-extend from the top byte
				if (b[SIGN_BIT] && off_size < 4'd8)
					off_acc |= ~64'd0 << (8 * off_size);
				wide_sum = {1'b0, cluster_total} + {1'b0, len_acc};
				cluster_total = wide_sum[VALUE_W] ? '1 : wide_sum[VALUE_W-1:0];
				res.run_length = len_acc;
				res.run_offset = off_acc;
				res.status = STATUS_OK;
				res.list_done = cluster_total > {1'b0, lcn_limit};
				if (res.list_done)
					list_ended = 1'b1;
				dec_phase = SEEK_HEADER;
				byte_pos = '0;
				return 1'b1;
			end
			default: begin
				ls = b[3:0];
				os = b[7:4];
				if (ls < SIZE_MIN || ls > SIZE_MAX || os < SIZE_MIN || os > SIZE_MAX) begin
					res = BAD_RUN;
					list_ended = 1'b1;
					dec_phase = SEEK_HEADER;
					return 1'b1;
				end
				len_size = ls;
				off_size = os;
				byte_pos = '0;
				len_acc = '0;
				off_acc = '0;
				dec_phase = TAKE_LENGTH;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report_failure(input string what, input run_result_t want,
			input run_result_t got);
		failures++;
		if (failures <= REPORT_MAX) begin
			$display("%s: expected len=%h off=%h status=%b done=%b", what,
				want.run_length, want.run_offset, want.status, want.list_done);
			$display("    actual   len=%h off=%h status=%b done=%b",
				got.run_length, got.run_offset, got.status, got.list_done);
		end
	endtask

	// Check results, predict from accepted bytes, track limit writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_run.run_length = m_axis_tdata[VALUE_W-1:0];
				seen_run.run_offset = m_axis_tdata[2*VALUE_W-1:VALUE_W];
				seen_run.status     = m_axis_tuser;
				seen_run.list_done  = m_axis_tlast;
				if (pending_runs.size() == 0) begin
					report_failure("unexpected run", NO_RUN, seen_run);
				end else begin
					wanted_run = pending_runs.pop_front();
					if (seen_run.run_length !== wanted_run.run_length ||
							seen_run.run_offset !== wanted_run.run_offset ||
							seen_run.status !== wanted_run.status ||
							seen_run.list_done !== wanted_run.list_done)
						report_failure("run mismatch", wanted_run, seen_run);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				run_due = decode_byte(s_axis_tdata, s_axis_tuser, predicted_run, byte_used);
				if (byte_used)
					decoded_items++;
				if (pin_valid)
					pending_runs = {pending_runs, pin_run};
				else if (run_due)
					pending_runs = {pending_runs, predicted_run};
			end
			if (cfg_we)
				lcn_limit = cfg_wdata;
		end
	end

	// Receiver: switch between always ready, coin toss and a trickle
	always @(posedge clk) begin
		rx_tick <= rx_tick + 32'd1;
		if (rx_tick % 200 == 0)
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
		case (rx_mode)
			RX_OPEN:    m_axis_tready <= 1'b1;
			RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
			RX_TRICKLE: m_axis_tready <= (rx_tick[2:0] == 3'd0);
			default:    m_axis_tready <= 1'b1;
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Send one byte, hold until accepted, then sometimes idle between bursts
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic st,
			input logic pin, input run_result_t run);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= st;
		pin_valid     <= pin;
		pin_run       <= run;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 7) == 0)
				steady = ~steady;
			if (!steady) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// Let every expected run drain, then give the pipeline time to settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		pin_valid <= 1'b0;
		@(posedge clk);
		while (pending_runs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One run: header, length bytes, offset bytes; sometimes corrupt or cut short
	task automatic send_run(input logic first);
		logic [SIZE_W-1:0]  ls, os;
		logic [BYTE_W-1:0]  hdr;
		logic               wide_len;
		int                 cut;
		ls = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(1, 3));
		os = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(1, 3));
		hdr = {os, ls};
		if ($urandom_range(0, 11) == 0)
			hdr = 8'($urandom);
		wide_len = ($urandom_range(0, 3) == 0);
		cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : 99;
		push_byte(hdr, first, 1'b0, NO_RUN);
		for (int i = 0; i < ls && cut > 0; i++, cut--)
			push_byte((i == 0 || wide_len) ? 8'($urandom) : 8'h00, 1'b0, 1'b0, NO_RUN);
		for (int i = 0; i < os && cut > 0; i++, cut--)
			push_byte(8'($urandom), 1'b0, 1'b0, NO_RUN);
	endtask

	task automatic send_list(input int runs);
		for (int r = 0; r < runs; r++)
			send_run(r == 0);
		// trailing noise: ignored after an ended list, decoded otherwise
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				push_byte(8'($urandom), ($urandom_range(0, 7) == 0), 1'b0, NO_RUN);
	endtask

	initial begin
		int target;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		pin_valid     <= 1'b0;
		pin_run       <= NO_RUN;
		m_axis_tready <= 1'b0;
		rx_tick       <= '0;
		rx_mode       <= RX_OPEN;
		dec_phase     = SEEK_HEADER;
		len_size      = '0;
		off_size      = '0;
		byte_pos      = '0;
		len_acc       = '0;
		off_acc       = '0;
		cluster_total = '0;
		list_ended    = 1'b1;
		lcn_limit     = '0;
		decoded_items = 0;
		failures      = 0;
		cycle_count   = 0;
		burst_left    = 0;
		steady        = 1'b0;
		limit_set[0] = '1;
		limit_set[1] = '0;
		limit_set[2] = 63'($urandom_range(1, 5000));
		limit_set[3] = 63'({$urandom, $urandom});
		limit_set[4] = 63'h0_FFFFF;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bytes with the reset limit of zero
		foreach (stim_table[i])
			push_byte(stim_table[i].data, stim_table[i].start, stim_table[i].pinned,
				stim_table[i].run);

		// Random lists under each limit setting
		foreach (limit_set[k]) begin
			write_limit(limit_set[k]);
			target = decoded_items + ITEMS_PER_SET;
			while (decoded_items < target)
				send_list($urandom_range(1, 6));
		end

		wait_idle();
		if (pending_runs.size() != 0)
			report_failure("run never arrived", pending_runs[0], NO_RUN);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
